// ----- rtl/ile_pkg.sv -----
// shared constants, codes and controller/datapath interface types for the list engine
package ile_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int LEN_W    = 7;
    localparam int FPOS_W   = 6;
    localparam int STAT_W   = 2;
    localparam int SCAN_W   = $clog2(CAPACITY);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_READ   = 3'd2,
        OP_FIND   = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_FILL   = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } stat_t;

    typedef struct packed {
        logic load;
        logic apply;
        logic scan_step;
    } ile_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } ile_sts_t;

endpackage

// ----- rtl/ile_ctrl.sv -----
// controller state machine: sequences request capture, update, scan and result strobe
module ile_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  ile_pkg::ile_sts_t sts,
    output ile_pkg::ile_cmd_t cmd,
    output logic            busy,
    output logic            done
);
    import ile_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_APPLY = 4'b0010,
        S_SCAN  = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.apply     = 1'b0;
        cmd.scan_step = 1'b0;
        busy          = 1'b1;
        done          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = sts.need_scan ? S_SCAN : S_RESP;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/ile_datapath.sv -----
// datapath: shifting entry chain, length counter, scan logic and result registers
module ile_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ile_pkg::ile_cmd_t           cmd,
    output ile_pkg::ile_sts_t           sts,
    input  logic [ile_pkg::OP_W-1:0]    operation,
    input  logic [ile_pkg::POS_W-1:0]   position,
    input  logic [ile_pkg::DATA_W-1:0]  value,
    input  logic [ile_pkg::LEN_W-1:0]   fill_length,
    output logic [ile_pkg::STAT_W-1:0]  status,
    output logic [ile_pkg::DATA_W-1:0]  read_value,
    output logic [ile_pkg::FPOS_W-1:0]  found_position,
    output logic [ile_pkg::LEN_W-1:0]   length
);
    import ile_pkg::*;

    logic [DATA_W-1:0] entries_reg  [CAPACITY];
    logic [DATA_W-1:0] entries_next [CAPACITY];
    logic [DATA_W-1:0] below_w      [CAPACITY];
    logic [DATA_W-1:0] above_w      [CAPACITY];
    logic [DATA_W-1:0] rot_w        [CAPACITY];

    logic [LEN_W-1:0]  count_reg;
    logic [LEN_W-1:0]  count_next;

    logic [OP_W-1:0]   op_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] val_reg;
    logic [LEN_W-1:0]  flen_reg;

    logic [STAT_W-1:0] stat_reg;
    logic [STAT_W-1:0] stat_next;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rd_next;
    logic [FPOS_W-1:0] fpos_reg;
    logic [FPOS_W-1:0] fpos_next;
    logic [SCAN_W-1:0] scan_idx_reg;
    logic [SCAN_W-1:0] scan_idx_next;
    logic              hit_reg;
    logic              hit_next;

    logic ins_ok;
    logic rem_ok;
    logic fill_ok;
    logic do_insert;
    logic do_remove;
    logic do_clear;
    logic do_fill;

    // range check comes before the full check
    assign ins_ok  = (pos_reg <= count_reg) && (count_reg != LEN_W'(CAPACITY));
    assign rem_ok  = pos_reg < count_reg;
    assign fill_ok = flen_reg <= LEN_W'(CAPACITY);

    assign do_insert = cmd.apply && (op_reg == OP_INSERT) && ins_ok;
    assign do_remove = cmd.apply && (op_reg == OP_REMOVE) && rem_ok;
    assign do_clear  = cmd.apply && (op_reg == OP_CLEAR);
    assign do_fill   = cmd.apply && (op_reg == OP_FILL) && fill_ok;

    assign sts.need_scan = (op_reg == OP_FIND) || ((op_reg == OP_READ) && rem_ok);
    assign sts.scan_last = scan_idx_reg == SCAN_W'(CAPACITY - 1);

    // neighbor taps; slots above the length hold zero outside a scan
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == 0)
            begin : g_bot
                assign below_w[g] = '0;
            end
            else
            begin : g_mid
                assign below_w[g] = entries_reg[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_top
                assign above_w[g] = '0;
                assign rot_w[g]   = entries_reg[0];
            end
            else
            begin : g_low
                assign above_w[g] = entries_reg[g+1];
                assign rot_w[g]   = entries_reg[g+1];
            end

            always_comb
            begin
                entries_next[g] = entries_reg[g];
                if (do_insert)
                begin
                    if (POS_W'(g) == pos_reg)
                    begin
                        entries_next[g] = val_reg;
                    end
                    else if (POS_W'(g) > pos_reg)
                    begin
                        entries_next[g] = below_w[g];
                    end
                end
                else if (do_remove)
                begin
                    if (POS_W'(g) >= pos_reg)
                    begin
                        entries_next[g] = above_w[g];
                    end
                end
                else if (do_clear)
                begin
                    entries_next[g] = '0;
                end
                else if (do_fill)
                begin
                    entries_next[g] = (LEN_W'(g) < flen_reg) ? val_reg : '0;
                end
                else if (cmd.scan_step)
                begin
                    // rotate the chain so each entry passes cell zero once
                    entries_next[g] = rot_w[g];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    entries_reg[g] <= '0;
                end
                else
                begin
                    entries_reg[g] <= entries_next[g];
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next    = count_reg;
        stat_next     = stat_reg;
        rd_next       = rd_reg;
        fpos_next     = fpos_reg;
        scan_idx_next = scan_idx_reg;
        hit_next      = hit_reg;
        if (cmd.apply)
        begin
            stat_next     = ST_OK;
            rd_next       = '0;
            fpos_next     = '0;
            scan_idx_next = '0;
            hit_next      = 1'b0;
            case (op_reg)
                OP_INSERT:
                begin
                    if (pos_reg > count_reg)
                    begin
                        stat_next = ST_RANGE;
                    end
                    else if (count_reg == LEN_W'(CAPACITY))
                    begin
                        stat_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + LEN_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    if (!rem_ok)
                    begin
                        stat_next = ST_RANGE;
                    end
                    else
                    begin
                        count_next = count_reg - LEN_W'(1);
                    end
                end
                OP_READ:
                begin
                    if (!rem_ok)
                    begin
                        stat_next = ST_RANGE;
                    end
                end
                OP_FIND:
                begin
                    stat_next = ST_NOTFOUND;
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                OP_FILL:
                begin
                    if (!fill_ok)
                    begin
                        stat_next = ST_RANGE;
                    end
                    else
                    begin
                        count_next = flen_reg;
                    end
                end
                default:
                begin
                    stat_next = ST_OK;
                end
            endcase
        end
        else if (cmd.scan_step)
        begin
            scan_idx_next = scan_idx_reg + SCAN_W'(1);
            if ((op_reg == OP_FIND) && !hit_reg && (LEN_W'(scan_idx_reg) < count_reg)
                && (entries_reg[0] == val_reg))
            begin
                hit_next  = 1'b1;
                fpos_next = FPOS_W'(scan_idx_reg);
                stat_next = ST_OK;
            end
            if ((op_reg == OP_READ) && (POS_W'(scan_idx_reg) == pos_reg))
            begin
                rd_next = entries_reg[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_idx_reg <= '0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            hit_reg      <= hit_next;
        end
    end

    // request and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            pos_reg  <= position;
            val_reg  <= value;
            flen_reg <= fill_length;
        end
        stat_reg <= stat_next;
        rd_reg   <= rd_next;
        fpos_reg <= fpos_next;
    end

    assign status         = stat_reg;
    assign read_value     = rd_reg;
    assign found_position = fpos_reg;
    assign length         = count_reg;

endmodule

// ----- rtl/indexed_list_engine_top.sv -----
// done follows the capture and apply steps for insert, remove, clear, fill, spare codes
// and refused requests, and a further scan step for read and find, which rotate the chain
// once past cell zero for the compare and read tap
// one request at a time: a new request is accepted only back in idle, with busy low
// the receiver cannot stall: each result is valid from the cycle done is high until the next request is applied
// reset (async, active low) empties the list and zeroes every entry at once
module indexed_list_engine_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    output logic                        done,
    input  logic [ile_pkg::OP_W-1:0]    operation,
    input  logic [ile_pkg::POS_W-1:0]   position,
    input  logic [ile_pkg::DATA_W-1:0]  value,
    input  logic [ile_pkg::LEN_W-1:0]   fill_length,
    output logic [ile_pkg::STAT_W-1:0]  status,
    output logic [ile_pkg::DATA_W-1:0]  read_value,
    output logic [ile_pkg::FPOS_W-1:0]  found_position,
    output logic [ile_pkg::LEN_W-1:0]   length
);
    import ile_pkg::*;

    ile_cmd_t cmd;
    ile_sts_t sts;

    ile_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ile_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .operation      (operation),
        .position       (position),
        .value          (value),
        .fill_length    (fill_length),
        .status         (status),
        .read_value     (read_value),
        .found_position (found_position),
        .length         (length)
    );

endmodule

// ----- dv/ile_list_checker.sv -----
// checker for the list engine: predicts each request's result and compares it on done
module ile_list_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        done,
    input  logic [ile_pkg::OP_W-1:0]    operation,
    input  logic [ile_pkg::POS_W-1:0]   position,
    input  logic [ile_pkg::DATA_W-1:0]  value,
    input  logic [ile_pkg::LEN_W-1:0]   fill_length,
    input  logic [ile_pkg::STAT_W-1:0]  status,
    input  logic [ile_pkg::DATA_W-1:0]  read_value,
    input  logic [ile_pkg::FPOS_W-1:0]  found_position,
    input  logic [ile_pkg::LEN_W-1:0]   length,
    output int                          errors,
    output int                          outstanding,
    output int                          checked
);
    import ile_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] rd;
        logic [FPOS_W-1:0] fpos;
        logic [LEN_W-1:0]  len;
    } list_result_t;

    logic [DATA_W-1:0] words [CAPACITY];
    logic [LEN_W-1:0]  word_count;
    list_result_t      pending_results [$];

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        errors++;
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // apply one request to the shadow list and queue what the block should answer
    task automatic predict_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                   input logic [DATA_W-1:0] val,
                                   input logic [LEN_W-1:0] flen);
        list_result_t r;
        int           hit;
        r = '0;
        r.status = ST_OK;
        hit = -1;
        case (op)
            OP_INSERT:
            begin
                // range check comes before the full check
                if (pos > word_count)
                    r.status = ST_RANGE;
                else if (word_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = word_count; i > pos; i--)
                        words[i] = words[i-1];
                    words[pos] = val;
                    word_count++;
                end
            end
            OP_REMOVE:
            begin
                if (pos >= word_count)
                    r.status = ST_RANGE;
                else
                begin
                    for (int i = pos; i + 1 < word_count; i++)
                        words[i] = words[i+1];
                    words[word_count-1] = '0;
                    word_count--;
                end
            end
            OP_READ:
            begin
                if (pos >= word_count)
                    r.status = ST_RANGE;
                else
                    r.rd = words[pos];
            end
            OP_FIND:
            begin
                for (int i = 0; i < word_count; i++)
                    if (hit < 0 && words[i] == val)
                        hit = i;
                if (hit < 0)
                    r.status = ST_NOTFOUND;
                else
                    r.fpos = FPOS_W'(hit);
            end
            OP_CLEAR:
            begin
                foreach (words[i])
                    words[i] = '0;
                word_count = '0;
            end
            OP_FILL:
            begin
                if (flen > CAPACITY)
                    r.status = ST_RANGE;
                else
                begin
                    foreach (words[i])
                        words[i] = (i < flen) ? val : '0;
                    word_count = flen;
                end
            end
            default:
            begin
                // spare codes leave the list alone
            end
        endcase
        r.len = word_count;
        pending_results.push_back(r);
    endtask

    task automatic check_result();
        list_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with no request outstanding", '0, '0);
        end
        else
        begin
            want = pending_results.pop_front();
            checked++;
            if (status !== want.status)
                report_mismatch("status", DATA_W'(status), DATA_W'(want.status));
            if (read_value !== want.rd)
                report_mismatch("read_value", read_value, want.rd);
            if (found_position !== want.fpos)
                report_mismatch("found_position", DATA_W'(found_position),
                                DATA_W'(want.fpos));
            if (length !== want.len)
                report_mismatch("length", DATA_W'(length), DATA_W'(want.len));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (words[i])
                words[i] = '0;
            word_count = '0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done === 1'b1)
                check_result();
            if (start === 1'b1 && busy === 1'b0)
                predict_request(operation, position, value, fill_length);
            outstanding <= pending_results.size();
        end
    end

endmodule

// ----- dv/indexed_list_engine_top_tb.sv -----
// testbench top for the list engine: clock, reset, request stimulus and verdict
module indexed_list_engine_top_tb;
    import ile_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
    localparam int N_RANDOM = 1725;
    localparam int QUIET_TAIL = 250;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               done;
    logic [OP_W-1:0]    operation;
    logic [POS_W-1:0]   position;
    logic [DATA_W-1:0]  value;
    logic [LEN_W-1:0]   fill_length;
    logic [STAT_W-1:0]  status;
    logic [DATA_W-1:0]  read_value;
    logic [FPOS_W-1:0]  found_position;
    logic [LEN_W-1:0]   length;

    int                 errors;
    int                 outstanding;
    int                 checked;
    int                 sent;
    int                 op_hits [8];
    logic [LEN_W-1:0]   last_len;
    logic [DATA_W-1:0]  word_pool [8];

    indexed_list_engine_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .done           (done),
        .operation      (operation),
        .position       (position),
        .value          (value),
        .fill_length    (fill_length),
        .status         (status),
        .read_value     (read_value),
        .found_position (found_position),
        .length         (length)
    );

    ile_list_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .done           (done),
        .operation      (operation),
        .position       (position),
        .value          (value),
        .fill_length    (fill_length),
        .status         (status),
        .read_value     (read_value),
        .found_position (found_position),
        .length         (length),
        .errors         (errors),
        .outstanding    (outstanding),
        .checked        (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // list length as last reported, used to aim positions (may lag by one request)
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_len <= '0;
        else if (done === 1'b1)
            last_len <= length;
    end

    task automatic issue(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] val, input logic [LEN_W-1:0] flen);
        start       <= 1'b1;
        operation   <= op;
        position    <= pos;
        value       <= val;
        fill_length <= flen;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sent++;
        op_hits[op]++;
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_word(input int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return word_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    initial
    begin
        int                 mode;
        int                 r;
        int                 wait_cycles;
        logic [OP_W-1:0]    op;
        logic [POS_W-1:0]   pos;
        logic [DATA_W-1:0]  val;
        logic [LEN_W-1:0]   flen;

        word_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                      32'h7FFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h1234_5678};
        rst_n       = 1'b0;
        start       = 1'b0;
        operation   = '0;
        position    = '0;
        value       = '0;
        fill_length = '0;
        mode        = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corners
        issue(OP_READ,   7'd0,  32'h0,          7'd0);
        issue(OP_REMOVE, 7'd0,  32'h0,          7'd0);
        issue(OP_FIND,   7'd0,  32'h0,          7'd0);
        issue(OP_INSERT, 7'd1,  32'hDEAD_BEEF,  7'd0);
        // build front, append, middle
        issue(OP_INSERT, 7'd0,  32'hFFFF_FFFF,  7'd0);
        issue(OP_INSERT, 7'd0,  32'h0000_0000,  7'd0);
        issue(OP_INSERT, 7'd2,  32'h8000_0000,  7'd0);
        issue(OP_INSERT, 7'd1,  32'h1234_5678,  7'd0);
        issue(OP_FIND,   7'd0,  32'hFFFF_FFFF,  7'd0);
        issue(OP_READ,   7'd3,  32'h0,          7'd0);
        issue(OP_REMOVE, 7'd1,  32'h0,          7'd0);
        issue(OP_READ,   7'd3,  32'h0,          7'd0);
        issue(OP_SPARE6, 7'd0,  32'hFFFF_FFFF,  7'd64);
        issue(OP_SPARE7, 7'd127, 32'h0,         7'd127);
        issue(OP_FILL,   7'd0,  32'h1111_1111,  7'd65);
        issue(OP_FILL,   7'd0,  32'h2222_2222,  7'd127);
        // full list: range is checked before full
        issue(OP_FILL,   7'd0,  32'hA5A5_A5A5,  7'd64);
        issue(OP_INSERT, 7'd64, 32'h0000_0001,  7'd0);
        issue(OP_INSERT, 7'd65, 32'h0000_0001,  7'd0);
        issue(OP_READ,   7'd63, 32'h0,          7'd0);
        issue(OP_FIND,   7'd0,  32'h5A5A_5A5A,  7'd0);
        issue(OP_REMOVE, 7'd63, 32'h0,          7'd0);
        issue(OP_READ,   7'd127, 32'h0,         7'd0);
        issue(OP_CLEAR,  7'd0,  32'h0,          7'd0);
        issue(OP_FILL,   7'd0,  32'h0,          7'd0);

        for (int k = 0; k < N_RANDOM; k++)
        begin
            // alternate between growing, shrinking and mixed stretches
            if (k % 150 == 0)
                mode = $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            if (r < (mode == 0 ? 55 : mode == 1 ? 20 : 35))
                op = OP_INSERT;
            else if (r < (mode == 0 ? 65 : 55))
                op = OP_REMOVE;
            else if (r < (mode == 0 ? 80 : 75))
                op = OP_READ;
            else if (r < 91)
                op = OP_FIND;
            else if (r < 93)
                op = OP_CLEAR;
            else if (r < 97)
                op = OP_FILL;
            else
                op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;

            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                if (op == OP_INSERT)
                    pos = POS_W'($urandom_range(0, last_len));
                else
                    pos = (last_len == 0) ? '0 : POS_W'($urandom_range(0, last_len - 1));
            end
            else if (r < 90)
                pos = last_len;
            else
                pos = POS_W'($urandom_range(0, 127));

            val = pick_word(op == OP_FIND ? 70 : 50);

            r = $urandom_range(0, 99);
            if (r < 10)
                flen = LEN_W'(CAPACITY);
            else if (r < 20)
                flen = LEN_W'($urandom_range(65, 127));
            else if (r < 60)
                flen = LEN_W'($urandom_range(0, 16));
            else
                flen = LEN_W'($urandom_range(0, 64));

            issue(op, pos, val, flen);

            if (k == N_RANDOM / 2)
            begin
                // let the block drain completely once
                start <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            else if (k < N_RANDOM - QUIET_TAIL && $urandom_range(0, 99) < 15)
            begin
                wait_cycles = $urandom_range(1, 8);
                if ($urandom_range(0, 1))
                begin
                    start <= 1'b0;
                    while (busy !== 1'b0)
                        @(posedge clk);
                    repeat (wait_cycles) @(posedge clk);
                end
                else
                    hold_off(wait_cycles);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        wait_cycles = 0;
        while (outstanding != 0 && wait_cycles < 200)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);

        $display("ran %0d requests: insert %0d, remove %0d, read %0d, find %0d, clear %0d, fill %0d",
                 sent, op_hits[OP_INSERT], op_hits[OP_REMOVE], op_hits[OP_READ],
                 op_hits[OP_FIND], op_hits[OP_CLEAR], op_hits[OP_FILL]);
        $display("spare codes %0d, results compared %0d, mismatches %0d, left waiting %0d",
                 op_hits[OP_SPARE6] + op_hits[OP_SPARE7], checked, errors, outstanding);
        if (errors == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
